// File: sv/sms_pkg.sv
// Shared constants, state encoding and control structs for the stable merge sorter.
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int SUM_W     = CNT_W + 1;
   localparam int KEY_W     = 32;
   localparam int TAG_W     = 16;
   localparam int ENTRY_W   = KEY_W + TAG_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_GROUP,
      ST_MERGE,
      ST_EMIT_PRIME,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic sort_init;
      logic group_init;
      logic merge_step;
      logic emit_init;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic has_prior;
      logic group_last;
      logic pass_end;
      logic sort_end;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

// File: sv/sms_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module sms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic      [WIDTH-1:0]         rd_a_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic      [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end

endmodule

`default_nettype wire

// File: sv/sms_ctrl.sv
// Sequencer for the sorter: load, merge passes and result emission.
`timescale 1ns / 1ps
`default_nettype none

module sms_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_last_item,
   input  wire sms_pkg::status_type status,
   output logic                    busy,
   output sms_pkg::cmd_type        cmd
);

   sms_pkg::state_type state_ff;
   sms_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sms_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sms_pkg::ST_LOAD: begin
            if (start && req_last_item) begin
               state_in = status.has_prior ? sms_pkg::ST_GROUP : sms_pkg::ST_EMIT_PRIME;
            end
         end
         sms_pkg::ST_GROUP: begin
            state_in = sms_pkg::ST_MERGE;
         end
         sms_pkg::ST_MERGE: begin
            if (status.group_last) begin
               if (status.pass_end && status.sort_end) begin
                  state_in = sms_pkg::ST_EMIT_PRIME;
               end else begin
                  state_in = sms_pkg::ST_GROUP;
               end
            end
         end
         sms_pkg::ST_EMIT_PRIME: begin
            state_in = sms_pkg::ST_EMIT;
         end
         sms_pkg::ST_EMIT: begin
            if (status.emit_last) begin
               state_in = sms_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = sms_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      busy           = (state_ff != sms_pkg::ST_LOAD);
      cmd.load       = (state_ff == sms_pkg::ST_LOAD) && start;
      cmd.sort_init  = (state_ff == sms_pkg::ST_LOAD) && start && req_last_item;
      cmd.group_init = (state_ff == sms_pkg::ST_GROUP);
      cmd.merge_step = (state_ff == sms_pkg::ST_MERGE);
      cmd.emit_init  = (state_ff == sms_pkg::ST_EMIT_PRIME);
      cmd.emit_step  = (state_ff == sms_pkg::ST_EMIT);
   end

endmodule

`default_nettype wire

// File: sv/sms_datapath.sv
// Sorter datapath: two record banks, merge pointers, comparator and result registers.
`timescale 1ns / 1ps
`default_nettype none

module sms_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sms_pkg::cmd_type            cmd,
   input  wire logic signed [sms_pkg::KEY_W-1:0] req_sort_key,
   input  wire logic [sms_pkg::TAG_W-1:0]   req_task_tag,
   output sms_pkg::status_type              status,
   output logic                             rsp_strobe,
   output logic signed [sms_pkg::KEY_W-1:0] rsp_sorted_key,
   output logic [sms_pkg::TAG_W-1:0]        rsp_sorted_tag,
   output logic                             rsp_final_result,
   output logic                             rsp_overflow
);

   localparam int CW = sms_pkg::CNT_W;
   localparam int AW = sms_pkg::ADDR_W;
   localparam int SW = sms_pkg::SUM_W;
   localparam int EW = sms_pkg::ENTRY_W;
   localparam int KW = sms_pkg::KEY_W;
   localparam int TW = sms_pkg::TAG_W;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [CW-1:0] k_ff, k_in;
   logic          src_ff, src_in;
   logic          strobe_ff;
   logic [KW-1:0] key_ff;
   logic [TW-1:0] tag_ff;
   logic          final_ff;
   logic          rsp_ovf_ff;

   logic [SW-1:0] n_ext, sum_mid, sum_hi, w2;
   logic [CW-1:0] mid_c, hi_c, k_inc, a_n, b_n;
   logic          take_left, room;
   logic [EW-1:0] rd0_a, rd0_b, rd1_a, rd1_b, rd_a, rd_b, merge_data;
   logic signed [KW-1:0] key_a, key_b;
   logic [AW-1:0] rd_a_addr, rd_b_addr, wr0_addr;
   logic [EW-1:0] wr0_data;
   logic          wr0_en, wr1_en;

   // Run bounds of the next group, clipped to the set size
   always_comb begin
      n_ext   = {1'b0, count_ff};
      sum_mid = {1'b0, lo_ff} + {1'b0, w_ff};
      sum_hi  = sum_mid + {1'b0, w_ff};
      w2      = {w_ff, 1'b0};
      mid_c   = (sum_mid < n_ext) ? sum_mid[CW-1:0] : count_ff;
      hi_c    = (sum_hi < n_ext) ? sum_hi[CW-1:0] : count_ff;
      k_inc   = k_ff + CW'(1);
      room    = (count_ff < CW'(sms_pkg::MAX_ITEMS));
   end

   // Merge decision on the two run heads
   always_comb begin
      rd_a       = src_ff ? rd1_a : rd0_a;
      rd_b       = src_ff ? rd1_b : rd0_b;
      key_a      = rd_a[EW-1 -: KW];
      key_b      = rd_b[EW-1 -: KW];
      take_left  = (a_ff < mid_ff) && ((b_ff >= hi_ff) || (key_a <= key_b));
      merge_data = take_left ? rd_a : rd_b;
      a_n        = a_ff + CW'(take_left);
      b_n        = b_ff + CW'(!take_left);
   end

   always_comb begin
      status.has_prior  = (count_ff != '0);
      status.group_last = (k_inc == hi_ff);
      status.pass_end   = (hi_ff == count_ff);
      status.sort_end   = (w2 >= n_ext);
      status.emit_last  = (k_inc == count_ff);
   end

   // Read addresses run one step ahead so the registered data lines up
   always_comb begin
      if (cmd.group_init) begin
         rd_a_addr = lo_ff[AW-1:0];
      end else if (cmd.merge_step) begin
         rd_a_addr = a_n[AW-1:0];
      end else if (cmd.emit_init) begin
         rd_a_addr = '0;
      end else if (cmd.emit_step) begin
         rd_a_addr = k_inc[AW-1:0];
      end else begin
         rd_a_addr = a_ff[AW-1:0];
      end
      rd_b_addr = cmd.group_init ? mid_c[AW-1:0] : b_n[AW-1:0];
   end

   always_comb begin
      wr0_en   = (cmd.load && room) || (cmd.merge_step && src_ff);
      wr0_addr = cmd.load ? count_ff[AW-1:0] : k_ff[AW-1:0];
      wr0_data = cmd.load ? {req_sort_key, req_task_tag} : merge_data;
      wr1_en   = cmd.merge_step && !src_ff;
   end

   sms_ram #(.WIDTH(EW), .DEPTH(sms_pkg::MAX_ITEMS)) u_bank0 (
      .clock     (clock),
      .wr_en     (wr0_en),
      .wr_addr   (wr0_addr),
      .wr_data   (wr0_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd0_a),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd0_b)
   );

   sms_ram #(.WIDTH(EW), .DEPTH(sms_pkg::MAX_ITEMS)) u_bank1 (
      .clock     (clock),
      .wr_en     (wr1_en),
      .wr_addr   (k_ff[AW-1:0]),
      .wr_data   (merge_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd1_a),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd1_b)
   );

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      w_in     = w_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.sort_init) begin
         w_in   = CW'(1);
         lo_in  = '0;
         src_in = 1'b0;
      end
      if (cmd.group_init) begin
         mid_in = mid_c;
         hi_in  = hi_c;
         a_in   = lo_ff;
         b_in   = mid_c;
         k_in   = lo_ff;
      end
      if (cmd.merge_step) begin
         a_in = a_n;
         b_in = b_n;
         k_in = k_inc;
         if (status.group_last) begin
            lo_in = hi_ff;
            if (status.pass_end) begin
               lo_in  = '0;
               w_in   = w2[CW-1:0];
               src_in = !src_ff;
            end
         end
      end
      if (cmd.emit_init) begin
         k_in = '0;
      end
      if (cmd.emit_step) begin
         k_in = k_inc;
         if (status.emit_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         w_ff      <= CW'(1);
         lo_ff     <= '0;
         mid_ff    <= '0;
         hi_ff     <= '0;
         a_ff      <= '0;
         b_ff      <= '0;
         k_ff      <= '0;
         src_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         w_ff      <= w_in;
         lo_ff     <= lo_in;
         mid_ff    <= mid_in;
         hi_ff     <= hi_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
         k_ff      <= k_in;
         src_ff    <= src_in;
         strobe_ff <= cmd.emit_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         key_ff     <= rd_a[EW-1 -: KW];
         tag_ff     <= rd_a[TW-1:0];
         final_ff   <= status.emit_last;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_key   = key_ff;
   assign rsp_sorted_tag   = tag_ff;
   assign rsp_final_result = final_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

// File: sv/stable_merge_sorter.sv
// Top level of the stable merge sorter: sequencer plus datapath.
//
// Usage: present a record on req_sort_key / req_task_tag / req_last_item and
// raise start; the beat is taken at the rising edge where start is high and
// busy is low. Records load at one beat per cycle into a 64-entry bank.
// Beats past 64 records are dropped and flag overflow on the whole set.
// The beat with req_last_item high closes the set: busy rises and the block
// runs a bottom-up merge sort, ping-ponging between two record banks, each
// a RAM with one write and two registered read ports. Each of the
// ceil(log2 n) passes writes one record per cycle, with a set-up step
// before each group of runs; a set of one record skips sorting.
// Then the read port is primed and n result beats follow back to back, each
// marked by rsp_strobe for one cycle, the last with rsp_final_result high.
// The receiver cannot stall: results are simply driven out. busy falls with
// the last result beat, so the next set may start on the following edge.
// Reset (synchronous, active high) empties the set and returns to loading.
`timescale 1ns / 1ps
`default_nettype none

module stable_merge_sorter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [sms_pkg::KEY_W-1:0] req_sort_key,
   input  wire logic [sms_pkg::TAG_W-1:0]   req_task_tag,
   input  wire logic                        req_last_item,
   output logic                             rsp_strobe,
   output logic signed [sms_pkg::KEY_W-1:0] rsp_sorted_key,
   output logic [sms_pkg::TAG_W-1:0]        rsp_sorted_tag,
   output logic                             rsp_final_result,
   output logic                             rsp_overflow
);

   sms_pkg::cmd_type    cmd;
   sms_pkg::status_type status;

   // Sequencer: hold busy from the closing beat until the last result
   sms_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_item (req_last_item),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   // Datapath: store records, merge runs, drive result beats
   sms_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sort_key     (req_sort_key),
      .req_task_tag     (req_task_tag),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_sorted_tag   (rsp_sorted_tag),
      .rsp_final_result (rsp_final_result),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for stable_merge_sorter: record sets against a sorted scoreboard.
`timescale 1ns / 1ps

module tb;

   localparam int KEY_W     = sms_pkg::KEY_W;
   localparam int TAG_W     = sms_pkg::TAG_W;
   localparam int MAX_ITEMS = sms_pkg::MAX_ITEMS;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
   localparam int RANDOM_RECORDS = 340;
   localparam int SETTLE_CYCLES  = 32;

   // How the keys of one random set are chosen.
   typedef enum int {
      KEYS_WIDE,   // full 32-bit range
      KEYS_TIED,   // a handful of values, so equal keys are common
      KEYS_EDGE    // extremes and values around zero
   } key_mix_type;

   // One record beat waiting to be driven, with its lead-in idle time.
   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
      logic                    last_item;
      int unsigned             gap;
      bit                      drain;   // hold until every sorted beat so far has come out
   } record_beat_type;

   // One record as held for sorting, and as expected on the result port.
   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
      logic                    final_result;
      logic                    overflow;
   } sorted_beat_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic signed [KEY_W-1:0] req_sort_key = '0;
   logic [TAG_W-1:0]        req_task_tag = '0;
   logic                    req_last_item = 1'b0;
   logic                    busy;
   logic                    rsp_strobe;
   logic signed [KEY_W-1:0] rsp_sorted_key;
   logic [TAG_W-1:0]        rsp_sorted_tag;
   logic                    rsp_final_result;
   logic                    rsp_overflow;

   record_beat_type pending_records[$];
   sorted_beat_type sorted_q[$];

   // Records of the set currently being collected by the predictor.
   sorted_beat_type held_set[MAX_ITEMS];
   int              held_count   = 0;
   bit              held_dropped = 1'b0;

   record_beat_type next_beat;
   bit              have_next = 1'b0;
   bit              took      = 1'b0;

   int records_taken = 0;
   int sets_closed   = 0;
   int overflow_sets = 0;
   int beats_checked = 0;
   int mismatches    = 0;

   stable_merge_sorter DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sort_key     (req_sort_key),
      .req_task_tag     (req_task_tag),
      .req_last_item    (req_last_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_sorted_tag   (rsp_sorted_tag),
      .rsp_final_result (rsp_final_result),
      .rsp_overflow     (rsp_overflow)
   );

   always #4 clock = ~clock;

   // Queue one record beat for the driver.
   task automatic push_beat(input logic signed [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input logic last_item, input int unsigned gap, input bit drain);
      record_beat_type b;
      b.key       = key;
      b.tag       = tag;
      b.last_item = last_item;
      b.gap       = gap;
      b.drain     = drain;
      pending_records.push_back(b);
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key(input key_mix_type mix);
      int near;
      case (mix)
         KEYS_TIED: begin
            near = $urandom_range(0, 6);
            return near - 3;
         end
         KEYS_EDGE: begin
            case ($urandom_range(0, 4))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return '0;
               3: return '1;
               default: return 1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Queue a whole set of random records; only the final one carries last_item.
   task automatic queue_set(input int len, input key_mix_type mix, input bit burst,
                            input bit drain);
      int unsigned gap;
      for (int i = 0; i < len; i++) begin
         if (burst || $urandom_range(0, 1) == 0) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 17);
         end
         push_beat(pick_key(mix), TAG_W'($urandom_range(0, 65535)), i == len - 1, gap,
                   drain && i == 0);
      end
   endtask

   // Driver: change inputs on the falling edge only. Once the current beat has
   // gone (or none is up), count down the next beat's idle time, honour any
   // drain hold, then present it. start gets one assignment per edge, so a
   // beat that follows with no gap keeps start high throughout.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (!have_next && pending_records.size() != 0) begin
            next_beat = pending_records.pop_front();
            have_next = 1'b1;
         end
         if (have_next && next_beat.gap == 0 && !(next_beat.drain && sorted_q.size() != 0)) begin
            req_sort_key  <= next_beat.key;
            req_task_tag  <= next_beat.tag;
            req_last_item <= next_beat.last_item;
            start         <= 1'b1;
            have_next = 1'b0;
         end else begin
            start <= 1'b0;
            if (have_next && next_beat.gap != 0) begin
               next_beat.gap--;
            end
         end
      end
   end

   // Predictor and checker, both on the rising edge. Check any result beat
   // first, then take in an accepted record: store it while there is room,
   // else drop it and flag the set. On the closing record, sort the held set
   // stably and queue the expected beats.
   always @(posedge clock) begin : scoreboard
      sorted_beat_type want;
      sorted_beat_type cur;
      int              j;

      if (!reset && rsp_strobe) begin
         if (sorted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("tb: unexpected result beat: key %0d tag %h final %b overflow %b",
                        rsp_sorted_key, rsp_sorted_tag, rsp_final_result, rsp_overflow);
            end
         end else begin
            want = sorted_q.pop_front();
            beats_checked++;
            if (rsp_sorted_key !== want.key || rsp_sorted_tag !== want.tag ||
                rsp_final_result !== want.final_result || rsp_overflow !== want.overflow) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("tb: mismatch on result %0d: expected key %0d tag %h final %b ovf %b",
                           beats_checked, want.key, want.tag, want.final_result, want.overflow);
                  $display("tb:                         got key %0d tag %h final %b ovf %b",
                           rsp_sorted_key, rsp_sorted_tag, rsp_final_result, rsp_overflow);
               end
            end
         end
      end

      took = !reset && start && !busy;
      if (took) begin
         records_taken++;
         if (held_count < MAX_ITEMS) begin
            held_set[held_count].key = req_sort_key;
            held_set[held_count].tag = req_task_tag;
            held_count++;
         end else begin
            held_dropped = 1'b1;
         end
         if (req_last_item) begin
            // Insertion sort: only strictly greater keys move right, so ties keep
            // their arrival order.
            for (int i = 1; i < held_count; i++) begin
               cur = held_set[i];
               j   = i;
               while (j > 0 && held_set[j-1].key > cur.key) begin
                  held_set[j] = held_set[j-1];
                  j--;
               end
               held_set[j] = cur;
            end
            for (int i = 0; i < held_count; i++) begin
               want              = held_set[i];
               want.final_result = (i == held_count - 1);
               want.overflow     = held_dropped;
               sorted_q.push_back(want);
            end
            sets_closed++;
            if (held_dropped) begin
               overflow_sets++;
            end
            held_count   = 0;
            held_dropped = 1'b0;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      int          made;
      int          set_no;
      int          len;
      int          pick;
      key_mix_type mix;

      // Directed sets: single records at both key extremes, a reversed pair,
      // a run of equal keys (with a drain hold in front), mixed ties around
      // zero, and an already sorted set.
      push_beat(KEY_MIN, 16'hffff, 1'b1, 0, 1'b0);
      push_beat(KEY_MAX, 16'h0000, 1'b1, 0, 1'b0);
      push_beat(KEY_MAX, 16'h0001, 1'b0, 0, 1'b0);
      push_beat(KEY_MIN, 16'h0002, 1'b1, 3, 1'b0);
      push_beat(5, 16'h0010, 1'b0, 0, 1'b1);
      push_beat(5, 16'h0011, 1'b0, 0, 1'b0);
      push_beat(5, 16'h0012, 1'b0, 1, 1'b0);
      push_beat(5, 16'h0013, 1'b1, 0, 1'b0);
      push_beat(-1, 16'h0020, 1'b0, 0, 1'b0);
      push_beat(0, 16'h0021, 1'b0, 0, 1'b0);
      push_beat(KEY_MAX, 16'h0022, 1'b0, 0, 1'b0);
      push_beat(KEY_MIN, 16'h0023, 1'b0, 2, 1'b0);
      push_beat(-1, 16'h0024, 1'b0, 0, 1'b0);
      push_beat(0, 16'h0025, 1'b1, 0, 1'b0);
      push_beat(KEY_MIN, 16'h5555, 1'b0, 0, 1'b0);
      push_beat(-1, 16'haaaa, 1'b0, 0, 1'b0);
      push_beat(0, 16'h00ff, 1'b0, 0, 1'b0);
      push_beat(1, 16'hff00, 1'b0, 0, 1'b0);
      push_beat(KEY_MAX, 16'h8001, 1'b1, 0, 1'b0);

      // Random sets, mostly small. One fills the store exactly; one runs two
      // past it, so its last two records, the closing one among them, are dropped.
      made   = 0;
      set_no = 0;
      while (made < RANDOM_RECORDS) begin
         if (set_no == 3) begin
            len = MAX_ITEMS;
         end else if (set_no == 12) begin
            len = MAX_ITEMS + 2;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               len = $urandom_range(1, 12);
            end else if (pick < 9) begin
               len = $urandom_range(13, 24);
            end else begin
               len = $urandom_range(25, 40);
            end
         end
         case ($urandom_range(0, 4))
            0, 1: mix = KEYS_TIED;
            2:    mix = KEYS_EDGE;
            default: mix = KEYS_WIDE;
         endcase
         queue_set(len, mix, $urandom_range(0, 3) == 0, set_no % 8 == 5);
         made += len;
         set_no++;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all beats sent, then every expected result seen, then settle.
      while (pending_records.size() != 0 || have_next || start || sorted_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("tb: %0d records in %0d sets (%0d with dropped records), %0d beats checked",
               records_taken, sets_closed, overflow_sets, beats_checked);
      $display("tb: sets of 1 to %0d records, keys wide, tied and at the extremes, %0d mismatches",
               MAX_ITEMS + 2, mismatches);
      if (mismatches == 0 && sorted_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
